FILE: hdl/gns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gns_pkg
// Shared types and constants of the gate netlist settle simulator.
// ----------------------------------------------------------------------------
package gns_pkg;

  localparam int GNS_MAX_GATES   = 32;
  localparam int GNS_NUM_SIGNALS = 32;
  localparam int IDX_W           = 5;
  localparam int IDX_SPAN        = 1 << IDX_W;
  localparam int GCNT_W          = 6;
  localparam int PASS_W          = 8;
  localparam int DATA_W          = 32;
  localparam int ADDR_W          = 3;

  localparam logic [GCNT_W-1:0] GATE_COUNT_RST = 6'd0;
  localparam logic [PASS_W-1:0] MAX_PASSES_RST = 8'd33;

  // Input opcodes.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_APPLY = 1'b1;

  // Gate functions.
  localparam logic KIND_NOT = 1'b0;
  localparam logic KIND_AND = 1'b1;

  // Register index, taken from paddr[2].
  localparam logic REG_GATE_COUNT = 1'b0;
  localparam logic REG_MAX_PASSES = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [IDX_W-1:0] in_b;
    logic [IDX_W-1:0] in_a;
    logic [IDX_W-1:0] out_sig;
  } gate_ent_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic issue;
    logic restart;
    logic tgl;
    logic out_load;
  } gns_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic more;
    logic pass_done;
    logic again;
  } gns_sts_t;

endpackage

FILE: hdl/gate_netlist_settle_sim.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gate_netlist_settle_sim
// Iterative settle simulator for a small netlist of NOT and AND gates.
// ----------------------------------------------------------------------------
// One item is handled at a time. A load item writes one gate entry; its result
// is loaded into the output register from the finish state once that register
// is free. An apply item with n active gates (n = min(gate_count, MAX_GATES,
// 32)) runs P settle passes and then a toggle pass: the gate table memory
// delivers one entry per cycle, so each pass reads the gates in order through
// a registered read, and the final pass over the table builds the toggle mask.
// With no active gates an apply item completes like a load. The result sits in
// an output register, so the next item may transfer while it waits.
// ----------------------------------------------------------------------------
module gate_netlist_settle_sim #(
  parameter int MAX_GATES   = gns_pkg::GNS_MAX_GATES,
  parameter int NUM_SIGNALS = gns_pkg::GNS_NUM_SIGNALS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gns_pkg::ADDR_W-1:0]    paddr,
  input  logic [gns_pkg::DATA_W-1:0]    pwdata,
  output logic [gns_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [4:0]                    in_gate_slot,
  input  logic                          in_gate_kind,
  input  logic [4:0]                    in_gate_out_signal,
  input  logic [4:0]                    in_gate_in_a,
  input  logic [4:0]                    in_gate_in_b,
  input  logic [31:0]                   in_drive_mask,
  input  logic [31:0]                   in_drive_values,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   out_signal_values,
  output logic [31:0]                   out_gate_toggled,
  output logic [7:0]                    out_pass_count,
  output logic                          out_not_settled
);
  import gns_pkg::*;

  gns_cmd_t          cmd;
  gns_sts_t          sts;
  logic [GCNT_W-1:0] gate_count;
  logic [PASS_W-1:0] max_passes;

  gns_regs u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .gate_count (gate_count),
    .max_passes (max_passes)
  );

  gns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  gns_dpath #(
    .MAX_GATES   (MAX_GATES),
    .NUM_SIGNALS (NUM_SIGNALS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .gate_count         (gate_count),
    .max_passes         (max_passes),
    .in_opcode          (in_opcode),
    .in_gate_slot       (in_gate_slot),
    .in_gate_kind       (in_gate_kind),
    .in_gate_out_signal (in_gate_out_signal),
    .in_gate_in_a       (in_gate_in_a),
    .in_gate_in_b       (in_gate_in_b),
    .in_drive_mask      (in_drive_mask),
    .in_drive_values    (in_drive_values),
    .out_signal_values  (out_signal_values),
    .out_gate_toggled   (out_gate_toggled),
    .out_pass_count     (out_pass_count),
    .out_not_settled    (out_not_settled)
  );

endmodule

FILE: hdl/gns_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gns_regs
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module gns_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gns_pkg::ADDR_W-1:0]    paddr,
  input  logic [gns_pkg::DATA_W-1:0]    pwdata,
  output logic [gns_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output logic [gns_pkg::GCNT_W-1:0]    gate_count,
  output logic [gns_pkg::PASS_W-1:0]    max_passes
);
  import gns_pkg::*;

  logic [GCNT_W-1:0] gate_count_r;
  logic [PASS_W-1:0] max_passes_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gate_count_r <= GATE_COUNT_RST;
      max_passes_r <= MAX_PASSES_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_GATE_COUNT: gate_count_r <= pwdata[GCNT_W-1:0];
        REG_MAX_PASSES: max_passes_r <= pwdata[PASS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_GATE_COUNT: prdata = DATA_W'(gate_count_r);
      REG_MAX_PASSES: prdata = DATA_W'(max_passes_r);
      default:        prdata = '0;
    endcase
  end

  assign gate_count = gate_count_r;
  assign max_passes = max_passes_r;

endmodule

FILE: hdl/gns_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gns_dpath
// Gate table memory, signal vector, sweep counter and result registers.
// ----------------------------------------------------------------------------
module gns_dpath #(
  parameter int MAX_GATES   = gns_pkg::GNS_MAX_GATES,
  parameter int NUM_SIGNALS = gns_pkg::GNS_NUM_SIGNALS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  gns_pkg::gns_cmd_t             cmd,
  output gns_pkg::gns_sts_t             sts,
  input  logic [gns_pkg::GCNT_W-1:0]    gate_count,
  input  logic [gns_pkg::PASS_W-1:0]    max_passes,
  input  logic                          in_opcode,
  input  logic [gns_pkg::IDX_W-1:0]     in_gate_slot,
  input  logic                          in_gate_kind,
  input  logic [gns_pkg::IDX_W-1:0]     in_gate_out_signal,
  input  logic [gns_pkg::IDX_W-1:0]     in_gate_in_a,
  input  logic [gns_pkg::IDX_W-1:0]     in_gate_in_b,
  input  logic [31:0]                   in_drive_mask,
  input  logic [31:0]                   in_drive_values,
  output logic [31:0]                   out_signal_values,
  output logic [31:0]                   out_gate_toggled,
  output logic [gns_pkg::PASS_W-1:0]    out_pass_count,
  output logic                          out_not_settled
);
  import gns_pkg::*;

  localparam int AW      = $clog2(MAX_GATES);
  localparam int SIW     = $clog2(NUM_SIGNALS);
  localparam int ACT_MAX = (MAX_GATES < 32) ? MAX_GATES : 32;
  localparam int CW      = $clog2(ACT_MAX + 1);

  gate_ent_t gate_mem [MAX_GATES];

  logic [NUM_SIGNALS-1:0] sig_r, sig_nxt, snap_r, forced;
  logic [CW-1:0]          cnt_r, n_act;
  logic                   iss_r, last_r;
  logic [IDX_W-1:0]       gidx_r;
  gate_ent_t              rd_ent_r, wr_ent;
  logic                   chg_acc_r, changed_r;
  logic [PASS_W-1:0]      passes_r, limit;
  logic [PASS_W:0]        pass_inc;
  logic [31:0]            tgl_r;
  logic [31:0]            out_sig_r, out_tgl_r;
  logic [PASS_W-1:0]      out_pass_r;
  logic                   out_ns_r;
  logic [SIW-1:0]         mod_tbl [IDX_SPAN];
  logic [SIW-1:0]         o_idx, a_idx, b_idx;
  logic                   ev_bit, sweep_ev, chg_now, chg_all;
  logic                   apply_go, load_go, slot_ok;
  logic [63:0]            mask_ext, val_ext, sig_ext;

  // Signal indexes wrap modulo the signal count.
  genvar gi;
  for (gi = 0; gi < IDX_SPAN; gi++) begin : g_mod
    assign mod_tbl[gi] = SIW'(gi % NUM_SIGNALS);
  end

  assign n_act = (gate_count > ACT_MAX) ? CW'(ACT_MAX) : gate_count[CW-1:0];
  assign limit = (max_passes == '0) ? PASS_W'(1) : max_passes;

  assign apply_go = cmd.accept & (in_opcode == OP_APPLY);
  assign load_go  = cmd.accept & (in_opcode == OP_LOAD);
  assign slot_ok  = 32'(in_gate_slot) < MAX_GATES;

  assign wr_ent.kind    = in_gate_kind;
  assign wr_ent.in_b    = in_gate_in_b;
  assign wr_ent.in_a    = in_gate_in_a;
  assign wr_ent.out_sig = in_gate_out_signal;

  assign mask_ext = 64'(in_drive_mask);
  assign val_ext  = 64'(in_drive_values);
  assign forced   = (sig_r & ~mask_ext[NUM_SIGNALS-1:0])
                  | (val_ext[NUM_SIGNALS-1:0] & mask_ext[NUM_SIGNALS-1:0]);

  always_comb begin
    o_idx    = mod_tbl[rd_ent_r.out_sig];
    a_idx    = mod_tbl[rd_ent_r.in_a];
    b_idx    = mod_tbl[rd_ent_r.in_b];
    ev_bit   = (rd_ent_r.kind == KIND_AND) ? (sig_r[a_idx] & sig_r[b_idx])
                                           : ~sig_r[a_idx];
    sweep_ev = iss_r & ~cmd.tgl;
    chg_now  = sweep_ev & (ev_bit != sig_r[o_idx]);
    chg_all  = chg_acc_r | chg_now;
    pass_inc = {1'b0, passes_r} + 1'b1;
    sig_nxt  = sig_r;
    if (apply_go) begin
      sig_nxt = forced;
    end else if (sweep_ev) begin
      sig_nxt[o_idx] = ev_bit;
    end
  end

  assign sts.empty     = (n_act == '0);
  assign sts.more      = (cnt_r < n_act);
  assign sts.pass_done = iss_r & last_r;
  assign sts.again     = chg_all & (pass_inc < {1'b0, limit});

  // Gate table: one write port for loads, one registered read for sweeps and the toggle pass.
  always_ff @(posedge clk) begin
    if (load_go && slot_ok) begin
      gate_mem[AW'(in_gate_slot)] <= wr_ent;
    end
    if (cmd.issue) begin
      rd_ent_r <= gate_mem[AW'(cnt_r)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_r     <= '0;
      cnt_r     <= '0;
      iss_r     <= 1'b0;
      last_r    <= 1'b0;
      chg_acc_r <= 1'b0;
      changed_r <= 1'b0;
      passes_r  <= '0;
      tgl_r     <= '0;
    end else begin
      sig_r  <= sig_nxt;
      iss_r  <= cmd.issue;
      last_r <= cmd.issue & (cnt_r == n_act - 1'b1);
      if (cmd.accept || cmd.restart) begin
        cnt_r <= '0;
      end else if (cmd.issue) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.accept) begin
        chg_acc_r <= 1'b0;
        changed_r <= 1'b0;
        tgl_r     <= '0;
        passes_r  <= (apply_go && sts.empty) ? PASS_W'(1) : '0;
      end else if (sweep_ev) begin
        chg_acc_r <= chg_all;
        if (sts.pass_done) begin
          passes_r  <= pass_inc[PASS_W-1:0];
          changed_r <= chg_all;
          chg_acc_r <= 1'b0;
        end
      end else if (iss_r && cmd.tgl) begin
        tgl_r[gidx_r] <= sig_r[o_idx] ^ snap_r[o_idx];
      end
    end
  end

  // Snapshot after forcing; the toggle pass compares each gate against it.
  always_ff @(posedge clk) begin
    if (apply_go) begin
      snap_r <= forced;
    end
    if (cmd.issue) begin
      gidx_r <= IDX_W'(cnt_r);
    end
  end

  assign sig_ext = 64'(sig_r);

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_sig_r  <= sig_ext[31:0];
      out_tgl_r  <= tgl_r;
      out_pass_r <= passes_r;
      out_ns_r   <= changed_r;
    end
  end

  assign out_signal_values = out_sig_r;
  assign out_gate_toggled  = out_tgl_r;
  assign out_pass_count    = out_pass_r;
  assign out_not_settled   = out_ns_r;

endmodule

FILE: hdl/gns_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gns_ctrl
// Sequencer: accept, settle sweeps, toggle pass and result hand-off.
// ----------------------------------------------------------------------------
module gns_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_opcode,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output gns_pkg::gns_cmd_t cmd,
  input  gns_pkg::gns_sts_t sts
);
  import gns_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_TOGGLE = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = ~out_valid_r | out_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_opcode == OP_LOAD || sts.empty) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SWEEP;
          end
        end
      end
      S_SWEEP: begin
        cmd.issue = sts.more;
        if (sts.pass_done) begin
          cmd.restart = 1'b1;
          state_nxt   = sts.again ? S_SWEEP : S_TOGGLE;
        end
      end
      S_TOGGLE: begin
        cmd.tgl   = 1'b1;
        cmd.issue = sts.more;
        if (sts.pass_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: test/gns_settle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gns_settle_checker
// Predicts every result of the gate netlist settle simulator and compares it.
// ----------------------------------------------------------------------------
// The checker follows register writes and item transfers, keeps its own copy
// of the gate table and signal vector, and queues one predicted result per
// item. Each result transfer is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module gns_settle_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [gns_pkg::ADDR_W-1:0]  paddr,
  input  logic [gns_pkg::DATA_W-1:0]  pwdata,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [4:0]                  in_gate_slot,
  input  logic                        in_gate_kind,
  input  logic [4:0]                  in_gate_out_signal,
  input  logic [4:0]                  in_gate_in_a,
  input  logic [4:0]                  in_gate_in_b,
  input  logic [31:0]                 in_drive_mask,
  input  logic [31:0]                 in_drive_values,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic [31:0]                 out_signal_values,
  input  logic [31:0]                 out_gate_toggled,
  input  logic [7:0]                  out_pass_count,
  input  logic                        out_not_settled,
  output int unsigned                 mismatches,
  output int unsigned                 pending,
  output int unsigned                 loads_done,
  output int unsigned                 settles_done,
  output int unsigned                 unsettled_done,
  output int unsigned                 deepest_settle
);
  import gns_pkg::*;

  typedef struct packed {
    logic [31:0]       signals;
    logic [31:0]       toggled;
    logic [PASS_W-1:0] passes;
    logic              unsettled;
  } settle_outcome_t;

  logic [31:0]       net_signals;
  gate_ent_t         gate_tab [GNS_MAX_GATES];
  logic [GCNT_W-1:0] active_count;
  logic [PASS_W-1:0] pass_limit;
  settle_outcome_t   outcome_q [$];
  settle_outcome_t   want;

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] wanted);
    if (mismatches < 40) begin
      $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, wanted);
    end
    mismatches++;
  endtask

  // Applies one item to the local netlist copy and queues what it must return.
  task automatic settle_netlist(input logic op, input logic [4:0] slot, input logic kind,
                                input logic [4:0] o, input logic [4:0] a,
                                input logic [4:0] b, input logic [31:0] mask,
                                input logic [31:0] vals);
    settle_outcome_t res;
    logic [31:0]     snap;
    logic            changed;
    logic            bit_new;
    int              n;
    int              lim;
    int              passes;
    int              g;
    res = '0;
    changed = 1'b0;
    passes = 0;
    if (op == OP_LOAD) begin
      gate_tab[slot] = {kind, b, a, o};
    end else begin
      n = (active_count > GNS_MAX_GATES) ? GNS_MAX_GATES : active_count;
      lim = (pass_limit == 0) ? 1 : pass_limit;
      net_signals = (net_signals & ~mask) | (vals & mask);
      snap = '0;
      for (g = 0; g < n; g++) snap[g] = net_signals[gate_tab[g].out_sig];
      // Each gate sees the updates made by the gates ahead of it in the sweep.
      do begin
        changed = 1'b0;
        for (g = 0; g < n; g++) begin
          if (gate_tab[g].kind == KIND_AND) begin
            bit_new = net_signals[gate_tab[g].in_a] & net_signals[gate_tab[g].in_b];
          end else begin
            bit_new = ~net_signals[gate_tab[g].in_a];
          end
          if (bit_new != net_signals[gate_tab[g].out_sig]) changed = 1'b1;
          net_signals[gate_tab[g].out_sig] = bit_new;
        end
        passes++;
      end while (changed && passes < lim);
      for (g = 0; g < n; g++) begin
        if (net_signals[gate_tab[g].out_sig] != snap[g]) res.toggled[g] = 1'b1;
      end
    end
    res.signals = net_signals;
    res.passes = PASS_W'(passes);
    res.unsettled = changed;
    outcome_q = {outcome_q, res};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      net_signals = '0;
      foreach (gate_tab[i]) gate_tab[i] = '0;
      active_count = GATE_COUNT_RST;
      pass_limit = MAX_PASSES_RST;
      outcome_q.delete();
      mismatches = 0;
      loads_done = 0;
      settles_done = 0;
      unsettled_done = 0;
      deepest_settle = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("result with nothing awaited", out_signal_values, '0);
        end else begin
          want = outcome_q.pop_front();
          if (out_signal_values !== want.signals) begin
            report_mismatch("signal_values", out_signal_values, want.signals);
          end
          if (out_gate_toggled !== want.toggled) begin
            report_mismatch("gate_toggled", out_gate_toggled, want.toggled);
          end
          if (out_pass_count !== want.passes) begin
            report_mismatch("pass_count", 32'(out_pass_count), 32'(want.passes));
          end
          if (out_not_settled !== want.unsettled) begin
            report_mismatch("not_settled", 32'(out_not_settled), 32'(want.unsettled));
          end
          // Only load items come back with a pass count of zero.
          if (want.passes == 0) begin
            loads_done++;
          end else begin
            settles_done++;
            if (want.unsettled) unsettled_done++;
            if (want.passes > deepest_settle) deepest_settle = want.passes;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_GATE_COUNT) begin
          active_count = pwdata[GCNT_W-1:0];
        end else begin
          pass_limit = pwdata[PASS_W-1:0];
        end
      end
      if (in_valid && in_ready) begin
        settle_netlist(in_opcode, in_gate_slot, in_gate_kind, in_gate_out_signal,
                       in_gate_in_a, in_gate_in_b, in_drive_mask, in_drive_values);
      end
    end
    pending = outcome_q.size();
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the gate netlist settle simulator.
// ----------------------------------------------------------------------------
// A directed opening covers empty tables, forced-signal extremes, oscillating
// gates and the pass limit. Random phases then load netlists and settle them
// under several register settings, with random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
  import gns_pkg::*;

  typedef struct {
    logic        op;
    logic [4:0]  slot;
    logic        kind;
    logic [4:0]  o;
    logic [4:0]  a;
    logic [4:0]  b;
    logic [31:0] mask;
    logic [31:0] vals;
  } gate_item_t;

  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid;
  logic              in_ready;
  logic              in_opcode;
  logic [4:0]        in_gate_slot;
  logic              in_gate_kind;
  logic [4:0]        in_gate_out_signal;
  logic [4:0]        in_gate_in_a;
  logic [4:0]        in_gate_in_b;
  logic [31:0]       in_drive_mask;
  logic [31:0]       in_drive_values;
  logic              out_valid;
  logic              out_ready;
  logic [31:0]       out_signal_values;
  logic [31:0]       out_gate_toggled;
  logic [7:0]        out_pass_count;
  logic              out_not_settled;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned loads_done;
  int unsigned settles_done;
  int unsigned unsettled_done;
  int unsigned deepest_settle;

  bit          idle_on = 1'b1;
  logic [31:0] slots_loaded = '0;
  int unsigned reg_writes = 0;

  gate_netlist_settle_sim dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_gate_slot       (in_gate_slot),
    .in_gate_kind       (in_gate_kind),
    .in_gate_out_signal (in_gate_out_signal),
    .in_gate_in_a       (in_gate_in_a),
    .in_gate_in_b       (in_gate_in_b),
    .in_drive_mask      (in_drive_mask),
    .in_drive_values    (in_drive_values),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_signal_values  (out_signal_values),
    .out_gate_toggled   (out_gate_toggled),
    .out_pass_count     (out_pass_count),
    .out_not_settled    (out_not_settled)
  );

  gns_settle_checker settle_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .pready             (pready),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_gate_slot       (in_gate_slot),
    .in_gate_kind       (in_gate_kind),
    .in_gate_out_signal (in_gate_out_signal),
    .in_gate_in_a       (in_gate_in_a),
    .in_gate_in_b       (in_gate_in_b),
    .in_drive_mask      (in_drive_mask),
    .in_drive_values    (in_drive_values),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_signal_values  (out_signal_values),
    .out_gate_toggled   (out_gate_toggled),
    .out_pass_count     (out_pass_count),
    .out_not_settled    (out_not_settled),
    .mismatches         (mismatches),
    .pending            (pending),
    .loads_done         (loads_done),
    .settles_done       (settles_done),
    .unsettled_done     (unsettled_done),
    .deepest_settle     (deepest_settle)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // The watchdog allows many times the slowest legal settle run.
  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Result side back-pressure in short random bursts.
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall = $urandom_range(0, 2);
        out_ready = 1'b0;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  function automatic gate_item_t load_op(input logic [4:0] slot, input logic kind,
                                         input logic [4:0] o, input logic [4:0] a,
                                         input logic [4:0] b);
    gate_item_t it;
    it.op = OP_LOAD;
    it.slot = slot;
    it.kind = kind;
    it.o = o;
    it.a = a;
    it.b = b;
    it.mask = $urandom;
    it.vals = $urandom;
    return it;
  endfunction

  function automatic gate_item_t apply_op(input logic [31:0] mask, input logic [31:0] vals);
    gate_item_t it;
    it = load_op(5'($urandom), 1'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
    it.op = OP_APPLY;
    it.mask = mask;
    it.vals = vals;
    return it;
  endfunction

  // Half the gates only read lower signal indexes, which tends to settle.
  function automatic gate_item_t random_load(input logic [4:0] slot);
    int o;
    o = $urandom_range(1, 31);
    if ($urandom_range(0, 1) == 1) begin
      return load_op(slot, 1'($urandom), 5'(o), 5'($urandom_range(0, o - 1)),
                     5'($urandom_range(0, o - 1)));
    end
    return load_op(slot, 1'($urandom), 5'($urandom), 5'($urandom), 5'($urandom));
  endfunction

  function automatic gate_item_t random_apply();
    logic [31:0] m;
    logic [31:0] v;
    int          pick;
    pick = $urandom_range(0, 9);
    m = $urandom;
    v = $urandom;
    case (pick)
      0: m = '1;
      1: m = '0;
      2: m = 32'h1 << $urandom_range(0, 31);
      3: v = '1;
      4: v = '0;
      default: ;
    endcase
    return apply_op(m, v);
  endfunction

  task automatic send_item(input gate_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 3);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_opcode = it.op;
    in_gate_slot = it.slot;
    in_gate_kind = it.kind;
    in_gate_out_signal = it.o;
    in_gate_in_a = it.a;
    in_gate_in_b = it.b;
    in_drive_mask = it.mask;
    in_drive_values = it.vals;
    do @(posedge clk); while (!in_ready);
    if (it.op == OP_LOAD) slots_loaded[it.slot] = 1'b1;
  endtask

  // Stops sending and waits until every result has been transferred.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    reg_writes++;
  endtask

  // Upper data bits may carry noise; only the register's own bits count.
  task automatic set_regs(input int gc, input int mp, input bit noisy);
    logic [31:0] junk;
    drain();
    junk = noisy ? $urandom : 32'h0;
    write_reg(REG_GATE_COUNT, (junk & ~32'h3F) | gc);
    junk = noisy ? $urandom : 32'h0;
    write_reg(REG_MAX_PASSES, (junk & ~32'hFF) | mp);
  endtask

  task automatic run_phase(input int gc, input int mp, input int count, input bit noisy);
    int live;
    int slot;
    set_regs(gc, mp, noisy);
    live = (gc > GNS_MAX_GATES) ? GNS_MAX_GATES : gc;
    repeat (count) begin
      if ($urandom_range(0, 99) < 45) begin
        if (live > 0 && $urandom_range(0, 9) < 7) slot = $urandom_range(0, live - 1);
        else slot = $urandom_range(0, 31);
        send_item(random_load(5'(slot)));
      end else begin
        send_item(random_apply());
      end
    end
  endtask

  initial begin : stimulus
    int s;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_opcode = OP_LOAD;
    in_gate_slot = '0;
    in_gate_kind = KIND_NOT;
    in_gate_out_signal = '0;
    in_gate_in_a = '0;
    in_gate_in_b = '0;
    in_drive_mask = '0;
    in_drive_values = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty table: forcing only, reported as a single pass.
    send_item(apply_op('1, '1));
    send_item(apply_op('1, '0));
    send_item(apply_op(32'hAAAA5555, '1));
    send_item(apply_op('0, '1));
    // Slot 0 is an inverter on its own output, so it never settles.
    send_item(load_op(5'd0, KIND_NOT, 5'd0, 5'd0, 5'd31));
    send_item(load_op(5'd1, KIND_AND, 5'd31, 5'd31, 5'd31));
    send_item(load_op(5'd31, KIND_AND, 5'd31, 5'd31, 5'd31));
    send_item(load_op(5'd2, KIND_NOT, 5'd3, 5'd2, 5'd0));
    send_item(load_op(5'd3, KIND_AND, 5'd4, 5'd3, 5'd1));
    set_regs(1, 1, 1'b0);
    send_item(apply_op(32'h1, 32'h0));
    // A limit of zero behaves as a limit of one.
    set_regs(1, 0, 1'b0);
    send_item(apply_op('0, '0));
    set_regs(2, 255, 1'b0);
    send_item(apply_op(32'h1, 32'h1));
    // Slot 0 now reads signal 2; once slot 2 drives it, settling needs extra sweeps.
    send_item(load_op(5'd0, KIND_NOT, 5'd1, 5'd2, 5'd0));
    set_regs(4, 33, 1'b0);
    send_item(apply_op('1, '0));
    send_item(apply_op(32'h4, 32'h4));
    send_item(load_op(5'd2, KIND_NOT, 5'd2, 5'd31, 5'd0));
    send_item(apply_op(32'h80000000, 32'h80000000));

    // Every table entry is written before any wider sweep reads it.
    for (s = 0; s < GNS_MAX_GATES; s++) begin
      if (!slots_loaded[s]) send_item(random_load(5'(s)));
    end

    run_phase(63, 4, 200, 1'b1);
    run_phase(32, 255, 15, 1'b0);
    run_phase($urandom_range(2, 12), $urandom_range(2, 10), 250, 1'b0);
    run_phase(0, $urandom_range(1, 255), 60, 1'b0);
    run_phase($urandom_range(1, 16), 33, 250, 1'b1);
    run_phase(8, 1, 180, 1'b0);
    idle_on = 1'b0;
    run_phase($urandom_range(1, 20), $urandom_range(1, 16), 300, 1'b0);

    drain();
    repeat (100) @(negedge clk);
    $display("Covered %0d gate loads and %0d settle runs across %0d register writes.",
             loads_done, settles_done, reg_writes);
    $display("%0d settle runs hit the pass limit; the longest took %0d passes.",
             unsettled_done, deepest_settle);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
